// ===== design/oish_pkg.sv =====
// Shared types and codes for the offset interval sample histogram.
package oish_pkg;

  localparam int MAX_SCHEMA_DEF  = 64;
  localparam int MAX_MAP_DEF     = 128;
  localparam int COUNT_WIDTH_DEF = 32;

  typedef enum logic [2:0] {
    CMD_CLEAR  = 3'd0,
    CMD_LOAD_S = 3'd1,
    CMD_LOAD_M = 3'd2,
    CMD_BUILD  = 3'd3,
    CMD_SAMPLE = 3'd4,
    CMD_READ   = 3'd5
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_BUILD_ERR = 3'd2,
    ST_RANGE     = 3'd3,
    ST_UNMATCHED = 3'd4
  } status_t;

  typedef struct packed {
    logic [2:0]         cmd;
    logic signed [31:0] source_offset;
    logic [31:0]        code_offset;
    logic [5:0]         entry_index;
  } request_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [5:0]         hit_index;
    logic [31:0]        interval_low;
    logic [31:0]        interval_high;
    logic signed [31:0] interval_source;
    logic [31:0]        sample_total;
  } result_t;

endpackage

// ===== design/oish_ram.sv =====
// Simple dual-port synchronous RAM with a registered read port.
module oish_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== design/oish_div.sv =====
// Restoring serial divider: 32-bit dividend, narrow divisor, one bit per cycle.
module oish_div #(
  parameter int DW = 7
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [31:0]   dividend,
  input  logic [DW-1:0] divisor,
  output logic          done,
  output logic [31:0]   quotient
);

  logic [DW:0]   rem;
  logic [DW-1:0] dsr;
  logic [5:0]    steps;
  logic          running;
  logic [DW:0]   trial;

  assign trial = {rem[DW-1:0], quotient[31]};

  // one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      steps   <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running  <= 1'b1;
        steps    <= 6'd0;
        rem      <= '0;
        dsr      <= divisor;
        quotient <= dividend;
      end else if (running) begin
        if (trial >= {1'b0, dsr}) begin
          rem <= trial - {1'b0, dsr};
          quotient <= {quotient[30:0], 1'b1};
        end else begin
          rem <= trial;
          quotient <= {quotient[30:0], 1'b0};
        end
        steps <= steps + 6'd1;
        if (steps == 6'd31) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== design/offset_interval_sample_histogram.sv =====
// Top level: command sequencer over the table, interval and counter memories.
// One command is taken at a time while busy is low; its single result appears on
// result for one cycle with done high and cannot be held off. Clear, loads, unused
// codes, refused reads and refused samples answer in the next cycle; a read answers
// from the registered memory outputs. A sample scans the intervals in index order,
// each as a memory read, then a compare. Build first sweeps every counter memory
// entry, then walks schema and map tables, then splits each hole run with a serial
// divide plus one write per hole.
module offset_interval_sample_histogram #(
  parameter int MAX_SCHEMA  = oish_pkg::MAX_SCHEMA_DEF,
  parameter int MAX_MAP     = oish_pkg::MAX_MAP_DEF,
  parameter int COUNT_WIDTH = oish_pkg::COUNT_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  oish_pkg::request_t request,
  output logic               done,
  output oish_pkg::result_t  result
);

  localparam int SW  = $clog2(MAX_SCHEMA + 1);
  localparam int SA  = $clog2(MAX_SCHEMA);
  localparam int MW  = $clog2(MAX_MAP + 1);
  localparam int MA  = $clog2(MAX_MAP);
  localparam int AW  = MW + 1;
  localparam int SPW = 65 + AW;

  typedef enum logic [16:0] {
    S_IDLE    = 17'h00001,
    S_CLR_CNT = 17'h00002,
    S_W_RD    = 17'h00004,
    S_W_EV    = 17'h00008,
    S_W_NXT   = 17'h00010,
    S_TAIL    = 17'h00020,
    S_R_RD    = 17'h00040,
    S_R_EV    = 17'h00080,
    S_J_RD    = 17'h00100,
    S_J_EV    = 17'h00200,
    S_B_RD    = 17'h00400,
    S_B_EV    = 17'h00800,
    S_B2_EV   = 17'h01000,
    S_DIV     = 17'h02000,
    S_FILL    = 17'h04000,
    S_SC_RD   = 17'h08000,
    S_SC_EV   = 17'h10000
  } state_t;

  state_t state;

  logic [SW-1:0]        schema_fill, span_count, s, i, j;
  logic [MW-1:0]        map_fill, m;
  logic                 built_valid;
  logic signed [AW-1:0] anchor;
  logic [31:0]          low_hold, base, cur, split;
  logic [31:0]          code_reg;
  logic [5:0]           idx_reg;
  logic                 rd_pend;

  // memory ports
  logic                   sch_we, map_we, spn_we, cnt_we;
  logic [SA-1:0]          sch_waddr, sch_raddr, spn_waddr, spn_raddr, cnt_waddr, cnt_raddr;
  logic [MA-1:0]          map_waddr, map_raddr;
  logic [31:0]            sch_wdata, sch_rdata;
  logic [63:0]            map_wdata, map_rdata;
  logic [SPW-1:0]         spn_wdata, spn_rdata;
  logic [COUNT_WIDTH-1:0] cnt_wdata, cnt_rdata;

  logic                 div_start, div_done;
  logic [31:0]          div_q;

  logic signed [31:0]   ms, ss;
  logic [31:0]          sp_low, sp_high;
  logic                 sp_hole;
  logic signed [AW-1:0] sp_anchor;
  logic [MW-1:0]        a_u;
  logic [63:0]          cnt_ext;
  logic [31:0]          cnt_sat;
  logic [COUNT_WIDTH-1:0] cnt_inc;

  assign busy = (state != S_IDLE) || rd_pend;

  assign ms        = $signed(map_rdata[63:32]);
  assign ss        = $signed(sch_rdata);
  assign sp_low    = spn_rdata[SPW-1 -: 32];
  assign sp_high   = spn_rdata[SPW-33 -: 32];
  assign sp_hole   = spn_rdata[AW];
  assign sp_anchor = $signed(spn_rdata[AW-1:0]);
  assign a_u       = MW'(anchor);
  assign cnt_ext   = 64'(cnt_rdata);
  assign cnt_sat   = (cnt_ext[63:32] != 32'd0) ? 32'hFFFF_FFFF : cnt_ext[31:0];
  assign cnt_inc   = (cnt_rdata == '1) ? cnt_rdata : cnt_rdata + COUNT_WIDTH'(1);

  // read address selection
  always_comb begin
    sch_raddr = SA'(request.entry_index);
    spn_raddr = SA'(request.entry_index);
    cnt_raddr = SA'(request.entry_index);
    map_raddr = m[MA-1:0];
    case (state)
      S_W_RD:  begin sch_raddr = s[SA-1:0]; map_raddr = m[MA-1:0]; end
      S_W_EV:  map_raddr = MA'(m + MW'(1));
      S_R_RD:  spn_raddr = i[SA-1:0];
      S_J_RD:  spn_raddr = j[SA-1:0];
      S_B_RD:  map_raddr = a_u[MA-1:0];
      S_B_EV:  map_raddr = MA'(a_u + MW'(1));
      S_SC_RD: begin
        sch_raddr = i[SA-1:0];
        spn_raddr = i[SA-1:0];
        cnt_raddr = i[SA-1:0];
      end
      default: ;
    endcase
  end

  // write port selection
  always_comb begin
    sch_we    = start && !busy && (request.cmd == oish_pkg::CMD_LOAD_S)
                && (schema_fill != SW'(MAX_SCHEMA));
    sch_waddr = schema_fill[SA-1:0];
    sch_wdata = request.source_offset;
    map_we    = start && !busy && (request.cmd == oish_pkg::CMD_LOAD_M)
                && (map_fill != MW'(MAX_MAP));
    map_waddr = map_fill[MA-1:0];
    map_wdata = {request.source_offset, request.code_offset};
    spn_we    = 1'b0;
    spn_waddr = s[SA-1:0];
    spn_wdata = {64'd0, 1'b1, AW'(m)};
    cnt_we    = 1'b0;
    cnt_waddr = i[SA-1:0];
    cnt_wdata = '0;
    div_start = 1'b0;
    case (state)
      S_CLR_CNT: cnt_we = 1'b1;
      S_W_EV: begin
        spn_we = (ms >= 0) && (ss < ms);
      end
      S_W_NXT: begin
        spn_we    = 1'b1;
        spn_wdata = {low_hold, map_rdata[31:0], 1'b0, AW'(0)};
      end
      S_TAIL: begin
        spn_we    = (s < schema_fill);
        spn_wdata = {64'd0, 1'b1, AW'(m) - AW'(2)};
      end
      S_B2_EV: div_start = 1'b1;
      S_FILL: begin
        spn_we    = 1'b1;
        spn_waddr = i[SA-1:0];
        spn_wdata = {cur, cur + split, 1'b1, anchor};
      end
      S_SC_EV: begin
        cnt_we    = (code_reg >= sp_low) && (code_reg < sp_high);
        cnt_wdata = cnt_inc;
      end
      default: ;
    endcase
  end

  // command sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      schema_fill <= '0;
      map_fill    <= '0;
      span_count  <= '0;
      built_valid <= 1'b0;
      done        <= 1'b0;
      rd_pend     <= 1'b0;
    end else begin
      done    <= 1'b0;
      rd_pend <= 1'b0;
      if (rd_pend) begin
        done                   <= 1'b1;
        result                 <= '0;
        result.hit_index       <= idx_reg;
        result.interval_low    <= sp_low;
        result.interval_high   <= sp_high;
        result.interval_source <= ss;
        result.sample_total    <= cnt_sat;
      end
      case (state)
        S_IDLE: begin
          if (start && !busy) begin
            result   <= '0;
            code_reg <= request.code_offset;
            idx_reg  <= request.entry_index;
            case (request.cmd)
              oish_pkg::CMD_CLEAR: begin
                schema_fill <= '0;
                map_fill    <= '0;
                span_count  <= '0;
                built_valid <= 1'b0;
                done        <= 1'b1;
              end
              oish_pkg::CMD_LOAD_S: begin
                done <= 1'b1;
                if (schema_fill == SW'(MAX_SCHEMA)) result.status <= oish_pkg::ST_FULL;
                else schema_fill <= schema_fill + SW'(1);
              end
              oish_pkg::CMD_LOAD_M: begin
                done <= 1'b1;
                if (map_fill == MW'(MAX_MAP)) result.status <= oish_pkg::ST_FULL;
                else map_fill <= map_fill + MW'(1);
              end
              oish_pkg::CMD_BUILD: begin
                built_valid <= 1'b0;
                span_count  <= '0;
                i           <= '0;
                state       <= S_CLR_CNT;
              end
              oish_pkg::CMD_SAMPLE: begin
                if (built_valid) begin
                  i     <= '0;
                  state <= S_SC_RD;
                end else begin
                  done          <= 1'b1;
                  result.status <= oish_pkg::ST_UNMATCHED;
                end
              end
              oish_pkg::CMD_READ: begin
                if (built_valid && (32'(request.entry_index) < 32'(span_count))) begin
                  rd_pend <= 1'b1;
                end else begin
                  done          <= 1'b1;
                  result.status <= oish_pkg::ST_RANGE;
                end
              end
              default: done <= 1'b1;
            endcase
          end
        end
        S_CLR_CNT: begin
          i <= i + SW'(1);
          if (i == SW'(MAX_SCHEMA - 1)) begin
            s     <= '0;
            m     <= MW'(1);
            state <= S_W_RD;
          end
        end
        S_W_RD: begin
          if ((m < map_fill) && (s < schema_fill)) state <= S_W_EV;
          else state <= S_TAIL;
        end
        S_W_EV: begin
          if (ms < 0) begin
            m     <= m + MW'(1);
            state <= S_W_RD;
          end else if (ss == ms) begin
            if ((m + MW'(1)) >= map_fill) begin
              done          <= 1'b1;
              result.status <= oish_pkg::ST_BUILD_ERR;
              state         <= S_IDLE;
            end else begin
              low_hold <= map_rdata[31:0];
              state    <= S_W_NXT;
            end
          end else if (ss < ms) begin
            s     <= s + SW'(1);
            state <= S_W_RD;
          end else begin
            m     <= m + MW'(1);
            state <= S_W_RD;
          end
        end
        S_W_NXT: begin
          s     <= s + SW'(1);
          m     <= m + MW'(1);
          state <= S_W_RD;
        end
        S_TAIL: begin
          if (s < schema_fill) begin
            s <= s + SW'(1);
          end else begin
            i     <= '0;
            state <= S_R_RD;
          end
        end
        S_R_RD: begin
          if (i < schema_fill) begin
            state <= S_R_EV;
          end else begin
            built_valid <= 1'b1;
            span_count  <= schema_fill;
            done        <= 1'b1;
            state       <= S_IDLE;
          end
        end
        S_R_EV: begin
          if (sp_hole) begin
            anchor <= sp_anchor;
            j      <= i + SW'(1);
            state  <= S_J_RD;
          end else begin
            i     <= i + SW'(1);
            state <= S_R_RD;
          end
        end
        S_J_RD: begin
          if (j < schema_fill) state <= S_J_EV;
          else if ((anchor < 0) || ((anchor + AW'(1)) >= $signed({1'b0, map_fill}))) begin
            done          <= 1'b1;
            result.status <= oish_pkg::ST_BUILD_ERR;
            state         <= S_IDLE;
          end else state <= S_B_RD;
        end
        S_J_EV: begin
          if (sp_hole && (sp_anchor == anchor)) begin
            j     <= j + SW'(1);
            state <= S_J_RD;
          end else if ((anchor < 0) || ((anchor + AW'(1)) >= $signed({1'b0, map_fill}))) begin
            done          <= 1'b1;
            result.status <= oish_pkg::ST_BUILD_ERR;
            state         <= S_IDLE;
          end else state <= S_B_RD;
        end
        S_B_RD: state <= S_B_EV;
        S_B_EV: begin
          base  <= map_rdata[31:0];
          cur   <= map_rdata[31:0];
          state <= S_B2_EV;
        end
        S_B2_EV: state <= S_DIV;
        S_DIV: begin
          if (div_done) begin
            split <= div_q;
            state <= S_FILL;
          end
        end
        S_FILL: begin
          cur <= cur + split;
          i   <= i + SW'(1);
          if ((i + SW'(1)) == j) state <= S_R_RD;
        end
        S_SC_RD: begin
          if (i < span_count) begin
            state <= S_SC_EV;
          end else begin
            done          <= 1'b1;
            result.status <= oish_pkg::ST_UNMATCHED;
            state         <= S_IDLE;
          end
        end
        S_SC_EV: begin
          if ((code_reg >= sp_low) && (code_reg < sp_high)) begin
            done                   <= 1'b1;
            result.status          <= oish_pkg::ST_OK;
            result.hit_index       <= 6'(i);
            result.interval_low    <= sp_low;
            result.interval_high   <= sp_high;
            result.interval_source <= ss;
            result.sample_total    <= (64'(cnt_inc) > 64'h0000_0000_FFFF_FFFF)
                                      ? 32'hFFFF_FFFF : 32'(cnt_inc);
            state                  <= S_IDLE;
          end else begin
            i     <= i + SW'(1);
            state <= S_SC_RD;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  oish_ram #(.WIDTH(32), .DEPTH(MAX_SCHEMA)) u_schema (
    .clk(clk), .we(sch_we), .waddr(sch_waddr), .wdata(sch_wdata),
    .raddr(sch_raddr), .rdata(sch_rdata)
  );

  oish_ram #(.WIDTH(64), .DEPTH(MAX_MAP)) u_map (
    .clk(clk), .we(map_we), .waddr(map_waddr), .wdata(map_wdata),
    .raddr(map_raddr), .rdata(map_rdata)
  );

  oish_ram #(.WIDTH(SPW), .DEPTH(MAX_SCHEMA)) u_span (
    .clk(clk), .we(spn_we), .waddr(spn_waddr), .wdata(spn_wdata),
    .raddr(spn_raddr), .rdata(spn_rdata)
  );

  oish_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(MAX_SCHEMA)) u_count (
    .clk(clk), .we(cnt_we), .waddr(cnt_waddr), .wdata(cnt_wdata),
    .raddr(cnt_raddr), .rdata(cnt_rdata)
  );

  oish_div #(.DW(SW)) u_div (
    .clk(clk), .rst(rst), .start(div_start),
    .dividend(map_rdata[31:0] - base), .divisor(j - i),
    .done(div_done), .quotient(div_q)
  );

`ifndef SYNTHESIS
  // an accepted command keeps the block busy or yields its result beat in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy || done)) else $error("accepted command dropped");
  // a result beat never comes out of an idle block with nothing pending
  a_done_had_work: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy || start)) else $error("result beat without a command");
  // a valid build never holds more intervals than the schema table can
  a_built_count: assert property (@(posedge clk) disable iff (rst)
    (built_valid && state == S_IDLE) |-> (span_count <= SW'(MAX_SCHEMA)))
    else $error("interval count out of range");
`endif

endmodule
